@@ rtl/core/nearest_keys_within_radius_assert.svh @@
// Assertion macros for the block's RTL (included by nkr_back).
`ifndef NEAREST_KEYS_WITHIN_RADIUS_ASSERT_SVH
`define NEAREST_KEYS_WITHIN_RADIUS_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define NKR_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Implication whose consequent is checked in the next cycle.
`define NKR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

@@ rtl/core/nkr_pkg.sv @@
// ---------------------------------------------------------------------------
// nkr_pkg
// Types and constants shared by the nearest-key search block.
// ---------------------------------------------------------------------------
package nkr_pkg;
	localparam int CODE_BITS = 8;
	localparam int DIST_BITS = 27;
	localparam int RANK_BITS = 3;
	localparam int PICK_BITS = 4;
	localparam int SLOT_BITS = 5;
	localparam int CFG_IDX_BITS = 1;
	localparam int CFG_DATA_BITS = 27;
	localparam logic [CFG_IDX_BITS-1:0] REG_RADIUS_SQ = 1'b0;
	localparam logic [CFG_IDX_BITS-1:0] REG_PICK_COUNT = 1'b1;
	localparam logic [DIST_BITS-1:0] DIST_MAX = {DIST_BITS{1'b1}};
	localparam logic [PICK_BITS-1:0] PICK_RESET = 4'd3;

	typedef struct packed {
		logic [CODE_BITS-1:0] code;
		logic [DIST_BITS-1:0] sq_dist;
		logic [RANK_BITS-1:0] rank;
		logic empty_res;
		logic last;
	} result_t;
endpackage

@@ rtl/core/nkr_ram.sv @@
// ---------------------------------------------------------------------------
// nkr_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module nkr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

@@ rtl/core/nkr_front.sv @@
// ---------------------------------------------------------------------------
// nkr_front
// Request intake: applies loads to the slot table, queues queries.
// ---------------------------------------------------------------------------
module nkr_front #(
	parameter int NUM_SLOTS = 32,
	parameter int COORD_BITS = 13
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  valid,
	output logic                  ready,
	input  logic                  kind,
	input  logic [4:0]            slot,
	input  logic                  slot_used,
	input  logic [7:0]            key_code,
	input  logic [12:0]           key_x,
	input  logic [12:0]           key_y,
	input  logic [12:0]           point_x,
	input  logic [12:0]           point_y,
	// slot table write side
	output logic                  tbl_we,
	output logic [$clog2(NUM_SLOTS)-1:0] tbl_waddr,
	output logic [7:0]            tbl_code,
	output logic [COORD_BITS-1:0] tbl_x,
	output logic [COORD_BITS-1:0] tbl_y,
	output logic [NUM_SLOTS-1:0]  present,
	// query queue toward the back end
	output logic                  q_valid,
	input  logic                  q_ready,
	output logic [COORD_BITS-1:0] q_px,
	output logic [COORD_BITS-1:0] q_py
);
	localparam int AW = $clog2(NUM_SLOTS);
	localparam int QD = 2;

	logic [COORD_BITS-1:0] qx_q [QD];
	logic [COORD_BITS-1:0] qy_q [QD];
	logic                  wp_q, rp_q;
	logic [1:0]            cnt_q;
	logic                  push, pop, in_range;
	logic [NUM_SLOTS-1:0]  present_q;
	logic                  q_valid_busy;

	// Loads go straight to the table; the back end never reads while a
	// load could race it, since loads wait while a query is queued or running.
	assign ready = (kind == 1'b0) ? !q_valid_busy : (cnt_q != 2'(QD));
	assign q_valid_busy = (cnt_q != 2'd0) || q_ready == 1'b0;

	assign in_range = ({3'd0, slot} < 8'(NUM_SLOTS)) || (NUM_SLOTS > 32);
	assign tbl_we = valid && ready && !kind && in_range;
	assign tbl_waddr = AW'(slot);
	assign tbl_code = key_code;
	assign tbl_x = COORD_BITS'(key_x);
	assign tbl_y = COORD_BITS'(key_y);
	assign present = present_q;

	assign push = valid && ready && kind;
	assign pop = q_valid && q_ready;
	assign q_valid = cnt_q != 2'd0;
	assign q_px = qx_q[rp_q];
	assign q_py = qy_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_q <= '0;
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (tbl_we) begin
				present_q[tbl_waddr] <= slot_used;
			end
			if (push) begin
				wp_q <= !wp_q;
			end
			if (pop) begin
				rp_q <= !rp_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			qx_q[wp_q] <= COORD_BITS'(point_x);
			qy_q[wp_q] <= COORD_BITS'(point_y);
		end
	end
endmodule

@@ rtl/core/nkr_back.sv @@
// ---------------------------------------------------------------------------
// nkr_back
// Query engine: walks the slots, keeps a sorted top-k list, emits results.
// ---------------------------------------------------------------------------
`include "nearest_keys_within_radius_assert.svh"
module nkr_back #(
	parameter int NUM_SLOTS = 32,
	parameter int MAX_PICK = 8,
	parameter int COORD_BITS = 13
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_valid,
	output logic                          q_ready,
	input  logic [COORD_BITS-1:0]         q_px,
	input  logic [COORD_BITS-1:0]         q_py,
	input  logic [NUM_SLOTS-1:0]          present,
	input  logic [nkr_pkg::DIST_BITS-1:0] radius_sq,
	input  logic [nkr_pkg::PICK_BITS-1:0] pick_count,
	output logic [$clog2(NUM_SLOTS)-1:0]  tbl_raddr,
	input  logic [7:0]                    tbl_code,
	input  logic [COORD_BITS-1:0]         tbl_x,
	input  logic [COORD_BITS-1:0]         tbl_y,
	output logic                          out_valid,
	input  logic                          out_ready,
	output nkr_pkg::result_t              out_res
);
	import nkr_pkg::*;
	localparam int AW = $clog2(NUM_SLOTS);
	localparam int LW = $clog2(MAX_PICK + 1);
	localparam int IW = (MAX_PICK > 1) ? $clog2(MAX_PICK) : 1;
	localparam int SW = 2 * COORD_BITS + 1;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_SCAN = 4'b0010,
		ST_EMIT = 4'b0100,
		ST_DONE = 4'b1000
	} state_t;

	state_t                state_q;
	logic [COORD_BITS-1:0] px_q, py_q;
	logic [AW:0]           rd_q;      // address issued
	logic                  v_s1, v_s2;
	logic                  pres_s1, pres_s2;
	logic [7:0]            code_s2, code_s3;
	logic [COORD_BITS-1:0] dx_s2, dy_s2;
	logic [SW-1:0]         sq_s3;
	logic                  v_s3, ok_s3;
	logic [LW-1:0]         lim_q, n_q, oi_q;
	logic [7:0]            lc_q [MAX_PICK];
	logic [DIST_BITS-1:0]  ld_q [MAX_PICK];
	logic [DIST_BITS-1:0]  dist_s3;
	logic [MAX_PICK-1:0]   beat;
	logic                  scan_end;
	logic [LW-1:0]         lim_c;
	logic                  hit_s3;

	assign q_ready = state_q == ST_IDLE;
	assign tbl_raddr = rd_q[AW-1:0];
	assign lim_c = ({2'b0, pick_count} > 6'(MAX_PICK)) ? LW'(MAX_PICK)
		: LW'(pick_count);
	assign dist_s3 = (sq_s3 > SW'(DIST_MAX)) ? DIST_MAX : DIST_BITS'(sq_s3);
	assign scan_end = rd_q == (AW+1)'(NUM_SLOTS) && !v_s1 && !v_s2 && !v_s3;
	// A present slot inside the radius, with a pick limit of at least one.
	assign hit_s3 = v_s3 && ok_s3 && dist_s3 <= radius_sq && lim_q != '0;

	// Candidate beats entry i if nearer, or equal and higher code; an entry
	// that came earlier wins a full tie, so lower slots stay ahead.
	always_comb begin
		for (int i = 0; i < MAX_PICK; i++) begin
			beat[i] = (LW'(i) < n_q) && ((dist_s3 < ld_q[i]) ||
				(dist_s3 == ld_q[i] && code_s3 > lc_q[i]));
			if (LW'(i) >= n_q) begin
				beat[i] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rd_q <= '0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			n_q <= '0;
			oi_q <= '0;
			lim_q <= '0;
		end else begin
			v_s1 <= 1'b0;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			unique case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						state_q <= ST_SCAN;
						rd_q <= '0;
						n_q <= '0;
						oi_q <= '0;
						lim_q <= lim_c;
					end
				end
				ST_SCAN: begin
					if (rd_q != (AW+1)'(NUM_SLOTS)) begin
						v_s1 <= 1'b1;
						rd_q <= rd_q + 1'b1;
					end
					if (hit_s3) begin
						if (n_q != lim_q) begin
							n_q <= n_q + 1'b1;
						end
					end
					if (scan_end) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_ready || !out_valid) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_ready) begin
						if (out_res.last) begin
							state_q <= ST_IDLE;
						end else begin
							oi_q <= oi_q + 1'b1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE) begin
			px_q <= q_px;
			py_q <= q_py;
		end
		pres_s1 <= present[rd_q[AW-1:0]];
		pres_s2 <= pres_s1;
		code_s2 <= tbl_code;
		code_s3 <= code_s2;
		dx_s2 <= (px_q > tbl_x) ? px_q - tbl_x : tbl_x - px_q;
		dy_s2 <= (py_q > tbl_y) ? py_q - tbl_y : tbl_y - py_q;
		sq_s3 <= SW'(dx_s2 * dx_s2) + SW'(dy_s2 * dy_s2);
		ok_s3 <= pres_s2;
		if (hit_s3) begin
			// insert into the sorted list, shifting the tail down
			for (int i = MAX_PICK - 1; i >= 0; i--) begin
				if (beat[i]) begin
					if (i == 0 || !beat[(i == 0) ? 0 : i-1]) begin
						lc_q[i] <= code_s3;
						ld_q[i] <= dist_s3;
					end else begin
						lc_q[i] <= lc_q[(i == 0) ? 0 : i-1];
						ld_q[i] <= ld_q[(i == 0) ? 0 : i-1];
					end
				end
			end
		end
	end

	always_comb begin
		out_valid = state_q == ST_DONE;
		if (n_q == '0) begin
			out_res = '{code: '0, sq_dist: '0, rank: '0, empty_res: 1'b1, last: 1'b1};
		end else begin
			out_res.code = lc_q[IW'(oi_q)];
			out_res.sq_dist = ld_q[IW'(oi_q)];
			out_res.rank = RANK_BITS'(oi_q);
			out_res.empty_res = 1'b0;
			out_res.last = (oi_q + 1'b1) == n_q;
		end
	end

	`NKR_ASSERT_IMP(a_count_bound, clk, arst_n, 1'b1, n_q <= lim_q, "list overflow")
	`NKR_ASSERT_IMP(a_emit_in_list, clk, arst_n, out_valid && n_q != '0, oi_q < n_q, "bad index")
	`NKR_ASSERT_NEXT(a_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(oi_q), "emit moved")
endmodule

@@ rtl/core/nearest_keys_within_radius.sv @@
// ---------------------------------------------------------------------------
// nearest_keys_within_radius
// Key table with nearest-first radius search over the stored key centers.
// ---------------------------------------------------------------------------
// A load request writes one slot straight into the table. A query request is
// queued (two deep) and then walks all NUM_SLOTS slots through one
// registered-read table port and a three-stage distance pipe, inserting each
// hit into a sorted MAX_PICK list, then gives one result per cycle while the
// receiver is ready (one up to pick_count, at most MAX_PICK). The slot walk
// sets the rate; a new query starts only after the last result is taken.
// Loads wait while a query is queued or running so that the table stays stable.
module nearest_keys_within_radius #(
	parameter int NUM_SLOTS = 32,
	parameter int MAX_PICK = 8,
	parameter int COORD_BITS = 13
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        kind,
	input  logic [4:0]  slot,
	input  logic        slot_used,
	input  logic [7:0]  key_code,
	input  logic [12:0] key_x,
	input  logic [12:0] key_y,
	input  logic [12:0] point_x,
	input  logic [12:0] point_y,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [nkr_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [nkr_pkg::CFG_DATA_BITS-1:0] cfg_data,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  found_code,
	output logic [26:0] found_dist_sq,
	output logic [2:0]  rank,
	output logic        empty_res,
	output logic        last
);
	import nkr_pkg::*;
	localparam int AW = $clog2(NUM_SLOTS);

	logic [DIST_BITS-1:0]  radius_q;
	logic [PICK_BITS-1:0]  pick_q;
	logic                  we;
	logic [AW-1:0]         waddr, raddr;
	logic [7:0]            wcode, rcode;
	logic [COORD_BITS-1:0] wx, wy, rx, ry, qpx, qpy;
	logic [NUM_SLOTS-1:0]  present;
	logic                  qv, qr;
	result_t               res;

	// Hold config; taken any cycle.
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= '0;
			pick_q <= PICK_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_RADIUS_SQ:  radius_q <= cfg_data;
				REG_PICK_COUNT: pick_q <= cfg_data[PICK_BITS-1:0];
				default: ;
			endcase
		end
	end

	nkr_front #(.NUM_SLOTS(NUM_SLOTS), .COORD_BITS(COORD_BITS)) u_front (
		.clk, .arst_n, .valid(in_valid), .ready(in_ready), .kind, .slot, .slot_used,
		.key_code, .key_x, .key_y, .point_x, .point_y,
		.tbl_we(we), .tbl_waddr(waddr), .tbl_code(wcode), .tbl_x(wx), .tbl_y(wy),
		.present, .q_valid(qv), .q_ready(qr), .q_px(qpx), .q_py(qpy)
	);

	nkr_ram #(.WIDTH(8), .DEPTH(NUM_SLOTS)) u_code (
		.clk, .we, .waddr, .wdata(wcode), .raddr, .rdata(rcode));
	nkr_ram #(.WIDTH(COORD_BITS), .DEPTH(NUM_SLOTS)) u_x (
		.clk, .we, .waddr, .wdata(wx), .raddr, .rdata(rx));
	nkr_ram #(.WIDTH(COORD_BITS), .DEPTH(NUM_SLOTS)) u_y (
		.clk, .we, .waddr, .wdata(wy), .raddr, .rdata(ry));

	nkr_back #(.NUM_SLOTS(NUM_SLOTS), .MAX_PICK(MAX_PICK), .COORD_BITS(COORD_BITS)) u_back (
		.clk, .arst_n, .q_valid(qv), .q_ready(qr), .q_px(qpx), .q_py(qpy),
		.present, .radius_sq(radius_q), .pick_count(pick_q),
		.tbl_raddr(raddr), .tbl_code(rcode), .tbl_x(rx), .tbl_y(ry),
		.out_valid, .out_ready, .out_res(res)
	);

	assign found_code = res.code;
	assign found_dist_sq = res.sq_dist;
	assign rank = res.rank;
	assign empty_res = res.empty_res;
	assign last = res.last;
endmodule

@@ verif/tb.sv @@
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the nearest-key radius search: loads key slots,
// queries points under several radius and pick settings, and compares every
// result against a local model of the slot table and the sorted search.
// ---------------------------------------------------------------------------
module tb;
	import nkr_pkg::*;

	localparam int N_SLOTS = 32;
	localparam int PICK_MAX = 8;
	localparam int SETTLE_CYCLES = 80;    // longer than one slot walk
	localparam int STALL_LIMIT = 5000;    // cycles without any handshake
	localparam int HOLD_CYCLES = 400;     // long receiver hold-off

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic in_valid = 1'b0;
	logic in_ready;
	logic kind = 1'b0;
	logic [4:0] slot = '0;
	logic slot_used = 1'b0;
	logic [7:0] key_code = '0;
	logic [12:0] key_x = '0;
	logic [12:0] key_y = '0;
	logic [12:0] point_x = '0;
	logic [12:0] point_y = '0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_BITS-1:0] cfg_index = '0;
	logic [CFG_DATA_BITS-1:0] cfg_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [7:0] found_code;
	logic [26:0] found_dist_sq;
	logic [2:0] rank;
	logic empty_res;
	logic last;

	// Local copy of the key table and the registers.
	logic [7:0] tbl_code [N_SLOTS];
	logic [12:0] tbl_x [N_SLOTS];
	logic [12:0] tbl_y [N_SLOTS];
	logic [N_SLOTS-1:0] tbl_present;
	logic [DIST_BITS-1:0] cur_radius;
	logic [PICK_BITS-1:0] cur_pick;

	result_t pending_hits[$];
	int mismatches = 0;
	int results_seen = 0;
	int queries_sent = 0;
	int loads_sent = 0;
	bit idle_on = 1'b1;        // random gaps on both sides
	bit hold_req = 1'b0;       // ask the receiver for a long hold-off
	int idle_cnt = 0;
	int hold_cnt = 0;
	int quiet_cycles = 0;

	nearest_keys_within_radius dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.kind(kind), .slot(slot), .slot_used(slot_used), .key_code(key_code),
		.key_x(key_x), .key_y(key_y), .point_x(point_x), .point_y(point_y),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.out_valid(out_valid), .out_ready(out_ready),
		.found_code(found_code), .found_dist_sq(found_dist_sq), .rank(rank),
		.empty_res(empty_res), .last(last)
	);

	always #5 clk = ~clk;

	// Exact squared distance, saturated to the 27-bit range.
	function automatic logic [DIST_BITS-1:0] dist_sq(logic [12:0] ax, logic [12:0] ay,
			logic [12:0] bx, logic [12:0] by);
		logic [12:0] dx;
		logic [12:0] dy;
		logic [28:0] s;
		dx = (ax > bx) ? ax - bx : bx - ax;
		dy = (ay > by) ? ay - by : by - ay;
		s = dx * dx + dy * dy;
		return (s > DIST_MAX) ? DIST_MAX : s[DIST_BITS-1:0];
	endfunction

	// Predict the nearest-first hit list of one query point.
	task automatic predict_hits(logic [12:0] px, logic [12:0] py);
		logic [DIST_BITS-1:0] d [N_SLOTS];
		bit taken [N_SLOTS];
		int lim;
		int n;
		int best;
		result_t r;
		lim = (cur_pick > PICK_MAX) ? PICK_MAX : cur_pick;
		n = 0;
		for (int i = 0; i < N_SLOTS; i++) begin
			d[i] = dist_sq(px, py, tbl_x[i], tbl_y[i]);
			taken[i] = !tbl_present[i] || d[i] > cur_radius;
		end
		while (n < lim) begin
			best = -1;
			// Strict compare keeps the lower slot on a full tie.
			for (int i = 0; i < N_SLOTS; i++) begin
				if (!taken[i] && (best < 0 || d[i] < d[best] ||
						(d[i] == d[best] && tbl_code[i] > tbl_code[best])))
					best = i;
			end
			if (best < 0)
				break;
			taken[best] = 1'b1;
			r = '0;
			r.code = tbl_code[best];
			r.sq_dist = d[best];
			r.rank = n[RANK_BITS-1:0];
			pending_hits.push_back(r);
			n++;
		end
		if (n == 0) begin
			r = '0;
			r.empty_res = 1'b1;
			r.last = 1'b1;
			pending_hits.push_back(r);
		end else begin
			r = pending_hits.pop_back();
			r.last = 1'b1;
			pending_hits.push_back(r);
		end
	endtask

	// Send one request; hold valid and payload until it is taken.
	task automatic send_req(logic k, logic [4:0] s, logic u, logic [7:0] c,
			logic [12:0] kx, logic [12:0] ky, logic [12:0] px, logic [12:0] py);
		int gap;
		gap = (idle_on && $urandom_range(0, 2) == 0) ? $urandom_range(1, 4) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		slot <= s;
		slot_used <= u;
		key_code <= c;
		key_x <= kx;
		key_y <= ky;
		point_x <= px;
		point_y <= py;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		if (k == 1'b0) begin
			tbl_present[s] = u;
			tbl_code[s] = c;
			tbl_x[s] = kx;
			tbl_y[s] = ky;
			loads_sent++;
		end else begin
			predict_hits(px, py);
			queries_sent++;
		end
	endtask

	task automatic load_key(logic [4:0] s, logic u, logic [7:0] c, logic [12:0] kx,
			logic [12:0] ky);
		send_req(1'b0, s, u, c, kx, ky, 13'($urandom), 13'($urandom));
	endtask

	task automatic query_point(logic [12:0] px, logic [12:0] py);
		send_req(1'b1, 5'($urandom), 1'($urandom), 8'($urandom), 13'($urandom),
			13'($urandom), px, py);
	endtask

	// Drop valid, drain every pending result, then let the walk settle.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_hits.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write one register while the block is idle.
	task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
		drain();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		if (idx == REG_RADIUS_SQ)
			cur_radius = val[DIST_BITS-1:0];
		else
			cur_pick = val[PICK_BITS-1:0];
	endtask

	// Checker and receiver: compare each taken result, then pick next ready.
	always @(posedge clk) begin
		result_t want;
		if (out_valid && out_ready) begin
			results_seen++;
			if (pending_hits.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result code=%0d dist=%0d rank=%0d empty=%0b last=%0b",
						found_code, found_dist_sq, rank, empty_res, last);
			end else begin
				want = pending_hits.pop_front();
				if (found_code !== want.code || found_dist_sq !== want.sq_dist ||
						rank !== want.rank || empty_res !== want.empty_res ||
						last !== want.last) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch exp code=%0d dist=%0d rank=%0d empty=%0b last=%0b%s",
							want.code, want.sq_dist, want.rank, want.empty_res, want.last,
							$sformatf(" got code=%0d dist=%0d rank=%0d empty=%0b last=%0b",
							found_code, found_dist_sq, rank, empty_res, last));
				end
			end
		end
		// Hold off for a long stretch on request, else random short bursts.
		if (hold_req && hold_cnt == 0)
			hold_cnt = HOLD_CYCLES;
		if (hold_cnt > 0) begin
			hold_cnt--;
			if (hold_cnt == 0)
				hold_req = 1'b0;
			out_ready <= 1'b0;
		end else if (idle_cnt > 0) begin
			idle_cnt--;
			out_ready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 3) == 0) begin
			idle_cnt = $urandom_range(0, 3);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Watchdog: end the run when no handshake happens for too long.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)
				|| !arst_n)
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("timeout with %0d results pending", pending_hits.size());
			$display("tb failed");
			$finish;
		end
	end

	// Reset values: empty table answers empty, radius zero only hits exact points.
	task automatic test_reset_defaults();
		query_point(13'd0, 13'd8191);
		load_key(5'd0, 1'b1, 8'd65, 13'd100, 13'd200);
		query_point(13'd100, 13'd200);
		query_point(13'd101, 13'd200);
	endtask

	// Extremes, ties, clearing a slot, and the pick count clamp.
	task automatic test_directed();
		write_reg(REG_RADIUS_SQ, DIST_MAX);
		load_key(5'd31, 1'b1, 8'd255, 13'd8191, 13'd8191);
		load_key(5'd1, 1'b1, 8'd0, 13'd0, 13'd0);
		load_key(5'd2, 1'b1, 8'd10, 13'd10, 13'd0);
		load_key(5'd3, 1'b1, 8'd20, 13'd0, 13'd10);    // equal distance, higher code
		load_key(5'd4, 1'b1, 8'd20, 13'd10, 13'd0);    // same code too: lower slot wins
		query_point(13'd0, 13'd0);
		query_point(13'd8191, 13'd8191);
		write_reg(REG_PICK_COUNT, 27'd8);
		query_point(13'd0, 13'd0);
		write_reg(REG_PICK_COUNT, 27'd15);             // above the maximum, clamps
		query_point(13'd5, 13'd5);
		write_reg(REG_PICK_COUNT, 27'd0);              // zero gives the empty result
		query_point(13'd5, 13'd5);
		write_reg(REG_PICK_COUNT, 27'h7fffff1);        // upper data bits ignored
		load_key(5'd2, 1'b0, 8'd10, 13'd10, 13'd0);    // clear a slot
		query_point(13'd0, 13'd0);
		write_reg(REG_RADIUS_SQ, 27'd100);
		query_point(13'd0, 13'd0);
		query_point(13'd4000, 13'd4000);
	endtask

	// Clustered keys around random centers, with queries mostly nearby and some anywhere.
	task automatic test_random(int items);
		logic [12:0] cx;
		logic [12:0] cy;
		for (int n = 0; n < items; n++) begin
			if (n % 40 == 0) begin
				write_reg(REG_RADIUS_SQ, 27'($urandom_range(0, 1) ? ($urandom & DIST_MAX) >>
					$urandom_range(0, 26) : DIST_MAX));
				write_reg(REG_PICK_COUNT, 27'($urandom_range(0, 15)));
				cx = 13'($urandom);
				cy = 13'($urandom);
			end
			if ($urandom_range(0, 9) < 6)
				load_key(5'($urandom), $urandom_range(0, 5) != 0, 8'($urandom),
					13'(cx + $urandom_range(0, 511)), 13'(cy + $urandom_range(0, 511)));
			else if ($urandom_range(0, 3) != 0)
				query_point(13'(cx + $urandom_range(0, 511)),
					13'(cy + $urandom_range(0, 511)));
			else
				query_point(13'($urandom), 13'($urandom));
		end
	endtask

	// Long receiver hold-off while queries keep coming: the input must stall.
	task automatic test_backpressure();
		write_reg(REG_RADIUS_SQ, DIST_MAX);
		write_reg(REG_PICK_COUNT, 27'd8);
		hold_req = 1'b1;
		repeat (12)
			query_point(13'($urandom), 13'($urandom));
	endtask

	initial begin
		for (int i = 0; i < N_SLOTS; i++) begin
			tbl_code[i] = '0;
			tbl_x[i] = '0;
			tbl_y[i] = '0;
		end
		tbl_present = '0;
		cur_radius = '0;
		cur_pick = PICK_RESET;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_directed();
		test_random(160);
		test_backpressure();
		drain();
		idle_on = 1'b0;
		test_random(40);
		drain();
		$display("ran %0d loads and %0d queries, checked %0d results", loads_sent,
			queries_sent, results_seen);
		$display("settings covered radius zero to max, pick counts zero to fifteen");
		if (mismatches == 0 && pending_hits.size() == 0) begin
			$display("tb passed");
		end else begin
			$display("%0d mismatches, %0d results missing", mismatches, pending_hits.size());
			$display("tb failed");
		end
		$finish;
	end
endmodule
